// ----- src/irfc_pkg.sv -----
`default_nettype none

package irfc_pkg;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 64;
  localparam int CYC_W   = 32;
  localparam int EXT_W   = 35;
  localparam int LVL_W   = 6;
  localparam int CFG_IDX_W = 8;

  // Widths of the registers held in flops next to the file
  localparam int SIRR_W  = 19;
  localparam int ASTRR_W = 4;
  localparam int IPLR_W  = 5;

  // Parameter defaults
  localparam int NUM_REGS_DEF        = 64;
  localparam int SOFT_LEVEL_LOW_DEF  = 4;
  localparam int SOFT_LEVEL_HIGH_DEF = 19;
  localparam int EXT_LEVEL_LOW_DEF   = 20;
  localparam int EXT_LEVEL_HIGH_DEF  = 34;

  // Reset value of the machine check control register
  localparam logic [DATA_W-1:0] MCSR_RESET = 64'h6;

  // Write masks
  localparam logic [DATA_W-1:0] M_SIRR     = 64'h7fff0;
  localparam logic [DATA_W-1:0] M_ICSR     = 64'hffffff0300;
  localparam logic [DATA_W-1:0] M_PTBR     = 64'hffffffffc0000000;
  localparam logic [DATA_W-1:0] M_DC_TEST  = 64'h1ffb;
  localparam logic [DATA_W-1:0] M_ITB_ASN  = 64'h7f0;
  localparam logic [DATA_W-1:0] M_DTB_ASN  = 64'hfe00000000000000;
  localparam logic [DATA_W-1:0] M_MODE     = 64'h18;
  localparam logic [DATA_W-1:0] M_IPL      = 64'h1f;
  localparam logic [DATA_W-1:0] M_AST      = 64'hf;
  localparam logic [DATA_W-1:0] M_DC_MODE  = 64'h3f;
  localparam logic [DATA_W-1:0] M_EXC_ADDR = ~64'h2;

  // Register numbers
  localparam logic [IDX_W-1:0] R_ISR            = 6'd0;
  localparam logic [IDX_W-1:0] R_SIRR           = 6'd1;
  localparam logic [IDX_W-1:0] R_ASTRR          = 6'd2;
  localparam logic [IDX_W-1:0] R_ASTER          = 6'd3;
  localparam logic [IDX_W-1:0] R_EXC_ADDR       = 6'd4;
  localparam logic [IDX_W-1:0] R_EXC_SUM        = 6'd5;
  localparam logic [IDX_W-1:0] R_EXC_MASK       = 6'd6;
  localparam logic [IDX_W-1:0] R_PAL_BASE       = 6'd7;
  localparam logic [IDX_W-1:0] R_ICM            = 6'd8;
  localparam logic [IDX_W-1:0] R_IPLR           = 6'd9;
  localparam logic [IDX_W-1:0] R_INTID          = 6'd10;
  localparam logic [IDX_W-1:0] R_IFAULT_VA_FORM = 6'd11;
  localparam logic [IDX_W-1:0] R_IVPTBR         = 6'd12;
  localparam logic [IDX_W-1:0] R_ICSR           = 6'd13;
  localparam logic [IDX_W-1:0] R_IC_PERR_STAT   = 6'd14;
  localparam logic [IDX_W-1:0] R_PMCTR          = 6'd15;
  localparam logic [IDX_W-1:0] R_SCRATCH0       = 6'd16;
  localparam logic [IDX_W-1:0] R_SCRATCH23      = 6'd39;
  localparam logic [IDX_W-1:0] R_DTB_ASN        = 6'd40;
  localparam logic [IDX_W-1:0] R_DTB_CM         = 6'd41;
  localparam logic [IDX_W-1:0] R_VA             = 6'd42;
  localparam logic [IDX_W-1:0] R_VA_FORM        = 6'd43;
  localparam logic [IDX_W-1:0] R_MVPTBR         = 6'd44;
  localparam logic [IDX_W-1:0] R_CC             = 6'd45;
  localparam logic [IDX_W-1:0] R_CC_CTL         = 6'd46;
  localparam logic [IDX_W-1:0] R_MCSR           = 6'd47;
  localparam logic [IDX_W-1:0] R_DC_PERR_STAT   = 6'd48;
  localparam logic [IDX_W-1:0] R_DC_TEST_CTL    = 6'd49;
  localparam logic [IDX_W-1:0] R_DC_MODE        = 6'd52;
  localparam logic [IDX_W-1:0] R_MAF_MODE       = 6'd53;
  localparam logic [IDX_W-1:0] R_ITB_ASN        = 6'd54;
  localparam logic [IDX_W-1:0] R_MM_STAT        = 6'd55;
  localparam logic [IDX_W-1:0] R_HWINT_CLR      = 6'd59;
  localparam logic [IDX_W-1:0] R_SL_XMIT        = 6'd60;
  localparam logic [IDX_W-1:0] R_DC_FLUSH       = 6'd61;
  localparam logic [IDX_W-1:0] R_IC_FLUSH       = 6'd62;
  localparam logic [IDX_W-1:0] R_ALT_MODE       = 6'd63;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CHECK = 2'd2
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_value;
    logic [CYC_W-1:0]  cycle_now;
    logic [EXT_W-1:0]  ext_interrupts;
    logic              speculative;
  } item_t;

  typedef struct packed {
    logic              fault;
    logic              take;
    logic [LVL_W-1:0]  level;
    logic [EXT_W-1:0]  summary;
  } int_res_t;

  function automatic logic rd_ok(logic [IDX_W-1:0] idx);
    logic ok;
    ok = 1'b0;
    if (idx inside {[R_SCRATCH0:R_SCRATCH23]}) begin
      ok = 1'b1;
    end else if (idx inside {[R_ISR:R_PMCTR], R_DTB_CM, R_VA, R_VA_FORM, R_CC, R_MCSR,
                             R_DC_PERR_STAT, R_DC_MODE, R_MAF_MODE, R_MM_STAT}) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic wr_ok(logic [IDX_W-1:0] idx);
    logic ok;
    ok = 1'b0;
    if (idx inside {[R_SCRATCH0:R_SCRATCH23]}) begin
      ok = 1'b1;
    end else if (idx inside {R_SIRR, R_ASTRR, R_ASTER, R_EXC_ADDR, R_EXC_SUM, R_EXC_MASK,
                             R_PAL_BASE, R_ICM, R_IPLR, R_IVPTBR, R_ICSR, R_IC_PERR_STAT,
                             R_PMCTR, R_DTB_ASN, R_DTB_CM, R_MVPTBR, R_CC, R_CC_CTL,
                             R_MCSR, R_DC_PERR_STAT, R_DC_TEST_CTL, R_DC_MODE,
                             R_MAF_MODE, R_ITB_ASN, R_HWINT_CLR, R_SL_XMIT,
                             R_DC_FLUSH, R_IC_FLUSH, R_ALT_MODE}) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

  // Value stored by a permitted write
  function automatic logic [DATA_W-1:0] wr_val(logic [IDX_W-1:0] idx,
                                               logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v;
    case (idx)
      R_CC_CTL:                        r = 64'd1;
      R_EXC_ADDR:                      r = v & M_EXC_ADDR;
      R_ASTRR, R_ASTER:                r = v & M_AST;
      R_IPLR:                          r = v & M_IPL;
      R_DTB_CM, R_ICM, R_ALT_MODE:     r = v & M_MODE;
      R_SIRR:                          r = v & M_SIRR;
      R_ICSR:                          r = v & M_ICSR;
      R_IVPTBR, R_MVPTBR:              r = v & M_PTBR;
      R_DC_TEST_CTL:                   r = v & M_DC_TEST;
      R_DC_MODE, R_MAF_MODE:           r = v & M_DC_MODE;
      R_ITB_ASN:                       r = v & M_ITB_ASN;
      R_DTB_ASN:                       r = v & M_DTB_ASN;
      R_EXC_SUM, R_EXC_MASK:           r = '0;
      default:                         r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/irfc_if.sv -----
`default_nettype none

interface irfc_item_if;
  logic                         valid;
  logic                         ready;
  logic [irfc_pkg::ACT_W-1:0]   action;
  logic [irfc_pkg::IDX_W-1:0]   reg_index;
  logic [irfc_pkg::DATA_W-1:0]  write_value;
  logic [irfc_pkg::CYC_W-1:0]   cycle_now;
  logic [irfc_pkg::EXT_W-1:0]   ext_interrupts;
  logic                         speculative;

  modport source (output valid, action, reg_index, write_value, cycle_now,
                  ext_interrupts, speculative, input ready);
  modport sink   (input valid, action, reg_index, write_value, cycle_now,
                  ext_interrupts, speculative, output ready);
endinterface

interface irfc_result_if;
  logic                         valid;
  logic                         ready;
  logic [irfc_pkg::DATA_W-1:0]  read_data;
  logic                         access_fault;
  logic                         take_interrupt;
  logic [irfc_pkg::LVL_W-1:0]   int_level;
  logic [irfc_pkg::EXT_W-1:0]   int_summary;

  modport source (output valid, read_data, access_fault, take_interrupt, int_level,
                  int_summary, input ready);
  modport sink   (input valid, read_data, access_fault, take_interrupt, int_level,
                  int_summary, output ready);
endinterface

interface irfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [irfc_pkg::CFG_IDX_W-1:0] index;
  logic [irfc_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/irfc_regmem.sv -----
`default_nettype none

module irfc_regmem #(
  parameter int NUM_REGS = irfc_pkg::NUM_REGS_DEF,
  parameter int ADDR_W   = $clog2(NUM_REGS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [ADDR_W-1:0]           rd_addr_i,
  input  wire logic                        wr_en_i,
  input  wire logic [ADDR_W-1:0]           wr_addr_i,
  input  wire logic [irfc_pkg::DATA_W-1:0] wr_data_i,
  output logic      [irfc_pkg::DATA_W-1:0] rd_data_o
);
  import irfc_pkg::*;

  localparam logic [ADDR_W-1:0] MCSR_A = ADDR_W'(R_MCSR);

  logic [DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;

  logic [DATA_W-1:0] rd_mem_q;
  logic [DATA_W-1:0] byp_data_q;
  logic              rd_vld_q;
  logic              byp_q;
  logic              rd_mcsr_q;
  logic              byp_d;

  // A write landing on the address being read this edge wins over the array
  assign byp_d = rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q   <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
      rd_mcsr_q  <= (rd_addr_i == MCSR_A);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
        byp_q    <= byp_d;
      end
    end
  end

  // Entries never written read as their reset value
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_mem_q;
    end else if (rd_mcsr_q) begin
      rd_data_o = MCSR_RESET;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ----- src/irfc_int_check.sv -----
`default_nettype none

module irfc_int_check #(
  parameter int SOFT_LEVEL_LOW  = irfc_pkg::SOFT_LEVEL_LOW_DEF,
  parameter int SOFT_LEVEL_HIGH = irfc_pkg::SOFT_LEVEL_HIGH_DEF,
  parameter int EXT_LEVEL_LOW   = irfc_pkg::EXT_LEVEL_LOW_DEF,
  parameter int EXT_LEVEL_HIGH  = irfc_pkg::EXT_LEVEL_HIGH_DEF
) (
  input  wire logic [irfc_pkg::SIRR_W-1:0]  sirr_i,
  input  wire logic [irfc_pkg::ASTRR_W-1:0] astrr_i,
  input  wire logic [irfc_pkg::IPLR_W-1:0]  iplr_i,
  input  wire logic [irfc_pkg::EXT_W-1:0]   ext_i,
  output irfc_pkg::int_res_t                res_o
);
  import irfc_pkg::*;

  logic [63:0]      sirr_w;
  logic [63:0]      ext_w;
  logic [63:0]      summ_w;
  logic [LVL_W-1:0] level;

  assign sirr_w = 64'(sirr_i);
  assign ext_w  = 64'(ext_i);

  // Highest level wins: scan soft levels, then external levels on top
  always_comb begin
    level  = '0;
    summ_w = '0;
    for (int i = SOFT_LEVEL_LOW; i < SOFT_LEVEL_HIGH; i++) begin
      if (sirr_w[i]) begin
        level     = LVL_W'(i - SOFT_LEVEL_LOW + 1);
        summ_w[i] = 1'b1;
      end
    end
    for (int i = EXT_LEVEL_LOW; i < EXT_LEVEL_HIGH; i++) begin
      if (ext_w[i]) begin
        level     = LVL_W'(i);
        summ_w[i] = 1'b1;
      end
    end
  end

  always_comb begin
    if (astrr_i != '0) begin
      res_o = '{fault: 1'b1, take: 1'b0, level: '0, summary: '0};
    end else begin
      res_o.fault   = 1'b0;
      res_o.level   = level;
      res_o.summary = summ_w[EXT_W-1:0];
      res_o.take    = (level != '0) && (level > LVL_W'(iplr_i));
    end
  end

endmodule

`default_nettype wire

// ----- src/internal_reg_file_with_interrupt_check.sv -----
// Pipeline: an accepted item enters the input stage and moves on to the output
// register when that is free or being drained (one input stage, one result stage).
// Throughput: one item per cycle unless stalled; the register file is one array with
// one write and one registered read port, with a forward path from the write of the item ahead.
// Reset: asynchronous, active low; clears all handshake state and brings every
// register to zero except the machine check control register, which holds 6.
`default_nettype none

module internal_reg_file_with_interrupt_check #(
  parameter int NUM_REGS        = irfc_pkg::NUM_REGS_DEF,
  parameter int SOFT_LEVEL_LOW  = irfc_pkg::SOFT_LEVEL_LOW_DEF,
  parameter int SOFT_LEVEL_HIGH = irfc_pkg::SOFT_LEVEL_HIGH_DEF,
  parameter int EXT_LEVEL_LOW   = irfc_pkg::EXT_LEVEL_LOW_DEF,
  parameter int EXT_LEVEL_HIGH  = irfc_pkg::EXT_LEVEL_HIGH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  irfc_item_if.sink      in_i,
  irfc_result_if.source  res_o,
  irfc_cfg_if.sink       cfg_i
);
  import irfc_pkg::*;

  localparam int ADDR_W = $clog2(NUM_REGS);

  // ---------------------------------------------------------------------------
  // Configuration. The processor number and the code base only reach the file
  // through a reset, and reset returns them to zero, so the base and the
  // processor scratch entry reset to zero. Always take config items.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 advances whenever the output register is free or being
  // drained; the input side is open whenever stage 1 is empty or advancing.
  // ---------------------------------------------------------------------------
  logic  s1_valid_q;
  item_t s1_q;
  logic  out_valid_q;
  logic  adv;
  logic  in_acc;
  logic  fire;

  assign adv         = !out_valid_q || res_o.ready;
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign fire        = s1_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.action         <= in_i.action;
      s1_q.reg_index      <= in_i.reg_index;
      s1_q.write_value    <= in_i.write_value;
      s1_q.cycle_now      <= in_i.cycle_now;
      s1_q.ext_interrupts <= in_i.ext_interrupts;
      s1_q.speculative    <= in_i.speculative;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers kept in flops: the ones the interrupt check reads or writes.
  // Their entries in the array are never used.
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0]   isr_q;
  logic [SIRR_W-1:0]  sirr_q;
  logic [ASTRR_W-1:0] astrr_q;
  logic [IPLR_W-1:0]  iplr_q;
  logic [LVL_W-1:0]   intid_q;

  // ---------------------------------------------------------------------------
  // Register array. Issue the read as the item enters so the data lines up
  // with stage 1; indexes past the file are never read.
  // ---------------------------------------------------------------------------
  logic              mem_rd_en;
  logic              mem_we;
  logic [DATA_W-1:0] mem_rd_data;
  logic [DATA_W-1:0] wv;

  assign mem_rd_en = in_acc && (32'(in_i.reg_index) < NUM_REGS);

  irfc_regmem #(
    .NUM_REGS (NUM_REGS),
    .ADDR_W   (ADDR_W)
  ) u_regmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (ADDR_W'(in_i.reg_index)),
    .wr_en_i   (fire && mem_we),
    .wr_addr_i (ADDR_W'(s1_q.reg_index)),
    .wr_data_i (wv),
    .rd_data_o (mem_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Interrupt check: priority encode soft and external levels against IPL.
  // ---------------------------------------------------------------------------
  int_res_t chk;

  irfc_int_check #(
    .SOFT_LEVEL_LOW  (SOFT_LEVEL_LOW),
    .SOFT_LEVEL_HIGH (SOFT_LEVEL_HIGH),
    .EXT_LEVEL_LOW   (EXT_LEVEL_LOW),
    .EXT_LEVEL_HIGH  (EXT_LEVEL_HIGH)
  ) u_int_check (
    .sirr_i  (sirr_q),
    .astrr_i (astrr_q),
    .iplr_i  (iplr_q),
    .ext_i   (s1_q.ext_interrupts),
    .res_o   (chk)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 decode: read mux, write routing and fault.
  // ---------------------------------------------------------------------------
  logic              in_range;
  logic [DATA_W-1:0] rd_data;
  logic              fault;
  logic              take;
  logic [LVL_W-1:0]  lvl;
  logic [EXT_W-1:0]  summ;
  logic              sirr_we;
  logic              astrr_we;
  logic              iplr_we;
  logic              isr_we;

  assign in_range = 32'(s1_q.reg_index) < NUM_REGS;
  assign wv       = wr_val(s1_q.reg_index, s1_q.write_value);

  always_comb begin
    rd_data  = '0;
    fault    = 1'b0;
    take     = 1'b0;
    lvl      = '0;
    summ     = '0;
    mem_we   = 1'b0;
    sirr_we  = 1'b0;
    astrr_we = 1'b0;
    iplr_we  = 1'b0;
    isr_we   = 1'b0;
    case (action_e'(s1_q.action))
      ACT_READ: begin
        if (in_range && rd_ok(s1_q.reg_index)) begin
          case (s1_q.reg_index)
            R_ISR:   rd_data = DATA_W'(isr_q);
            R_SIRR:  rd_data = DATA_W'(sirr_q);
            R_ASTRR: rd_data = DATA_W'(astrr_q);
            R_IPLR:  rd_data = DATA_W'(iplr_q);
            R_INTID: rd_data = DATA_W'(intid_q);
            // Counter: stored upper half joined with the live cycle count
            R_CC:    rd_data = {mem_rd_data[DATA_W-1:CYC_W], s1_q.cycle_now};
            default: rd_data = mem_rd_data;
          endcase
        end else begin
          fault = 1'b1;
        end
      end
      ACT_WRITE: begin
        // Drop writes while misspeculating, without a fault
        if (!s1_q.speculative) begin
          if (in_range && wr_ok(s1_q.reg_index)) begin
            case (s1_q.reg_index)
              R_SIRR:  sirr_we  = 1'b1;
              R_ASTRR: astrr_we = 1'b1;
              R_IPLR:  iplr_we  = 1'b1;
              default: mem_we   = 1'b1;
            endcase
          end else begin
            fault = 1'b1;
          end
        end
      end
      ACT_CHECK: begin
        fault  = chk.fault;
        take   = chk.take;
        lvl    = chk.level;
        summ   = chk.summary;
        isr_we = chk.take;
      end
      default: begin
        fault = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isr_q   <= '0;
      sirr_q  <= '0;
      astrr_q <= '0;
      iplr_q  <= '0;
      intid_q <= '0;
    end else if (fire) begin
      if (sirr_we) begin
        sirr_q <= wv[SIRR_W-1:0];
      end
      if (astrr_we) begin
        astrr_q <= wv[ASTRR_W-1:0];
      end
      if (iplr_we) begin
        iplr_q <= wv[IPLR_W-1:0];
      end
      // Trap taken: record summary and level
      if (isr_we) begin
        isr_q   <= summ;
        intid_q <= lvl;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] out_data_q;
  logic              out_fault_q;
  logic              out_take_q;
  logic [LVL_W-1:0]  out_lvl_q;
  logic [EXT_W-1:0]  out_summ_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q  <= rd_data;
      out_fault_q <= fault;
      out_take_q  <= take;
      out_lvl_q   <= lvl;
      out_summ_q  <= summ;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.read_data      = out_data_q;
  assign res_o.access_fault   = out_fault_q;
  assign res_o.take_interrupt = out_take_q;
  assign res_o.int_level      = out_lvl_q;
  assign res_o.int_summary    = out_summ_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_take_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_take_q |-> !out_fault_q && (out_lvl_q != '0))
    else $error("trap reported together with a fault or a zero level");

  a_fault_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fault_q |-> (out_data_q == '0))
    else $error("faulting item returned nonzero read data");

  a_trap_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && isr_we |=> (isr_q == $past(summ)) && (intid_q == $past(lvl)))
    else $error("taken trap did not record summary and level");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty result register");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- bench/tb_internal_reg_file_with_interrupt_check.sv -----
`timescale 1ns / 100ps

module tb_internal_reg_file_with_interrupt_check;
  import irfc_pkg::*;

  // Action code the block does not define; it must fault.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Configuration register numbers, plus one the block does not know.
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_ID   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_BASE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 8'hff;

  // Scratch entry that receives the processor number at reset.
  localparam logic [IDX_W-1:0] R_CPU_SCRATCH = R_SCRATCH0 + 6'd16;
  // Test tag scratch of the data cache: no access at all.
  localparam logic [IDX_W-1:0] R_DC_TEST_TAG_TEMP = 6'd51;

  localparam int PHASE_ITEMS = 310;

  // One result as seen on the result channel.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              fault;
    logic              take;
    logic [LVL_W-1:0]  level;
    logic [EXT_W-1:0]  summary;
  } outcome_t;

  // Register file shadow: predicts each result and checks the block against it.
  class reg_file_scoreboard;
    logic [DATA_W-1:0] regs [NUM_REGS_DEF];
    // Configuration only lands in the file at a reset, so hold it aside.
    logic [7:0]        next_cpu_id;
    logic [DATA_W-1:0] next_pal_base;
    outcome_t          expect_q[$];
    int errors, results, traps, faults, reads, writes, checks;

    function new();
      next_cpu_id   = '0;
      next_pal_base = '0;
      foreach (regs[i]) regs[i] = '0;
      regs[R_PAL_BASE]    = next_pal_base;
      regs[R_MCSR]        = MCSR_RESET;
      regs[R_CPU_SCRATCH] = 64'(next_cpu_id);
    endfunction

    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] val);
      if (idx == CFG_CPU_ID) begin
        next_cpu_id = val[7:0];
      end else if (idx == CFG_PAL_BASE) begin
        next_pal_base = val;
      end
    endfunction

    function bit fetch_reg(input logic [IDX_W-1:0] idx, input logic [CYC_W-1:0] cyc,
                           output logic [DATA_W-1:0] data);
      data = '0;
      if ((idx >= R_SCRATCH0 && idx <= R_SCRATCH23) || idx <= R_PMCTR) begin
        data = regs[idx];
        return 1'b1;
      end
      case (idx)
        R_DTB_CM, R_VA, R_VA_FORM, R_MCSR, R_DC_PERR_STAT, R_DC_MODE, R_MAF_MODE,
        R_MM_STAT: begin
          data = regs[idx];
          return 1'b1;
        end
        R_CC: begin
          data = {regs[idx][DATA_W-1:CYC_W], cyc};
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function bit store_masked(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] keep;
      if (idx >= R_SCRATCH0 && idx <= R_SCRATCH23) begin
        regs[idx] = v;
        return 1'b1;
      end
      case (idx)
        R_PAL_BASE, R_IC_PERR_STAT, R_DC_PERR_STAT, R_PMCTR, R_CC, R_MCSR, R_HWINT_CLR,
        R_SL_XMIT, R_DC_FLUSH, R_IC_FLUSH: keep = v;
        R_CC_CTL:                         keep = 64'd1;
        R_EXC_ADDR:                       keep = v & M_EXC_ADDR;
        R_ASTRR, R_ASTER:                 keep = v & M_AST;
        R_IPLR:                           keep = v & M_IPL;
        R_DTB_CM, R_ICM, R_ALT_MODE:      keep = v & M_MODE;
        R_SIRR:                           keep = v & M_SIRR;
        R_ICSR:                           keep = v & M_ICSR;
        R_IVPTBR, R_MVPTBR:               keep = v & M_PTBR;
        R_DC_TEST_CTL:                    keep = v & M_DC_TEST;
        R_DC_MODE, R_MAF_MODE:            keep = v & M_DC_MODE;
        R_ITB_ASN:                        keep = v & M_ITB_ASN;
        R_DTB_ASN:                        keep = v & M_DTB_ASN;
        R_EXC_SUM, R_EXC_MASK:            keep = '0;
        default:                          return 1'b0;
      endcase
      regs[idx] = keep;
      return 1'b1;
    endfunction

    function void note_item(input item_t it);
      outcome_t          o;
      logic [DATA_W-1:0] rd;
      logic [DATA_W-1:0] sirr;
      int                lvl;
      o   = '0;
      lvl = 0;
      case (it.action)
        ACT_READ: begin
          reads++;
          if (fetch_reg(it.reg_index, it.cycle_now, rd)) o.data = rd;
          else o.fault = 1'b1;
        end
        ACT_WRITE: begin
          writes++;
          if (!it.speculative && !store_masked(it.reg_index, it.write_value)) o.fault = 1'b1;
        end
        ACT_CHECK: begin
          checks++;
          if (regs[R_ASTRR] != '0) begin
            o.fault = 1'b1;
          end else begin
            // Software levels count from one; external levels keep their line number.
            sirr = regs[R_SIRR];
            for (int i = SOFT_LEVEL_LOW_DEF; i < SOFT_LEVEL_HIGH_DEF; i++) begin
              if (sirr[i]) begin
                lvl = i - SOFT_LEVEL_LOW_DEF + 1;
                o.summary[i] = 1'b1;
              end
            end
            for (int i = EXT_LEVEL_LOW_DEF; i < EXT_LEVEL_HIGH_DEF; i++) begin
              if (it.ext_interrupts[i]) begin
                lvl = i;
                o.summary[i] = 1'b1;
              end
            end
            o.level = lvl[LVL_W-1:0];
            if (lvl != 0 && 64'(lvl) > regs[R_IPLR]) begin
              regs[R_ISR]   = 64'(o.summary);
              regs[R_INTID] = 64'(lvl);
              o.take = 1'b1;
              traps++;
            end
          end
        end
        default: o.fault = 1'b1;
      endcase
      if (o.fault) faults++;
      expect_q.push_back(o);
    endfunction

    function void check_result(input outcome_t got);
      outcome_t want;
      results++;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("[%0t] result with nothing outstanding: data=%h",
                                   $realtime, got.data);
        return;
      end
      want = expect_q.pop_front();
      if (got.data !== want.data || got.fault !== want.fault || got.take !== want.take ||
          got.level !== want.level || got.summary !== want.summary) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] result %0d mismatch", $realtime, results);
          $display("  exp data=%h fault=%b take=%b level=%0d summary=%h", want.data,
                   want.fault, want.take, want.level, want.summary);
          $display("  got data=%h fault=%b take=%b level=%0d summary=%h", got.data,
                   got.fault, got.take, got.level, got.summary);
        end
      end
    endfunction

    function int pending();
      return expect_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_idle_pct;

  irfc_item_if   in_if();
  irfc_result_if res_if();
  irfc_cfg_if    cfg_if();

  reg_file_scoreboard sb = new();

  internal_reg_file_with_interrupt_check dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // Watch both channels at the rising edge. Note the input first so that even a
  // result that appears together with its item would find its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_item('{action: in_if.action, reg_index: in_if.reg_index,
                       write_value: in_if.write_value, cycle_now: in_if.cycle_now,
                       ext_interrupts: in_if.ext_interrupts,
                       speculative: in_if.speculative});
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{data: res_if.read_data, fault: res_if.access_fault,
                          take: res_if.take_interrupt, level: res_if.int_level,
                          summary: res_if.int_summary});
      end
    end
  end

  // Stall the result channel at random, per the current phase.
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic item_t mk(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] val, input logic [CYC_W-1:0] cyc,
                               input logic [EXT_W-1:0] ext, input logic spec);
    item_t it;
    it.action         = act;
    it.reg_index      = idx;
    it.write_value    = val;
    it.cycle_now      = cyc;
    it.ext_interrupts = ext;
    it.speculative    = spec;
    return it;
  endfunction

  // Mix of zeros, all ones, small values and full random words.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return '1;
      3, 4:    return 64'($urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Quiet lines, a single line, or a random spread including the unused top bit.
  function automatic logic [EXT_W-1:0] rand_lines();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4, 5: return 35'(1) << $urandom_range(EXT_W - 1);
      default: return 35'({$urandom, $urandom});
    endcase
  endfunction

  // Registers that steer the interrupt check or carry special read behavior.
  function automatic logic [IDX_W-1:0] hot_index();
    case ($urandom_range(5))
      0:       return R_SIRR;
      1:       return R_IPLR;
      2:       return R_ASTRR;
      3:       return R_CC;
      4:       return R_ISR;
      default: return R_INTID;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it.cycle_now      = $urandom;
    it.write_value    = rand_word();
    it.ext_interrupts = rand_lines();
    it.speculative    = ($urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 35) it.action = ACT_READ;
    else if (pick < 70) it.action = ACT_WRITE;
    else if (pick < 96) it.action = ACT_CHECK;
    else it.action = ACT_UNUSED;
    it.reg_index = ($urandom_range(99) < 25) ? hot_index() : 6'($urandom_range(63));
    // Keep the trap request mostly clear, or nearly every check would just fault.
    if (it.action == ACT_WRITE && it.reg_index == R_ASTRR && $urandom_range(99) < 75) begin
      it.write_value = '0;
    end
    return it;
  endfunction

  // Offer one item; called at a falling edge, returns at a falling edge with
  // valid still high so the next item follows without a bubble.
  task automatic push_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          = 1'b1;
    in_if.action         = it.action;
    in_if.reg_index      = it.reg_index;
    in_if.write_value    = it.write_value;
    in_if.cycle_now      = it.cycle_now;
    in_if.ext_interrupts = it.ext_interrupts;
    in_if.speculative    = it.speculative;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.note_config(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) push_item(rand_item());
    in_if.valid = 1'b0;
  endtask

  // Wait out every outstanding result, then let the pipeline settle.
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    item_t plan[$];

    // Hold every input at a known value through reset.
    rst_ni               = 1'b0;
    src_idle_pct         = 30;
    sink_idle_pct        = 57;
    in_if.valid          = 1'b0;
    in_if.action         = ACT_READ;
    in_if.reg_index      = '0;
    in_if.write_value    = '0;
    in_if.cycle_now      = '0;
    in_if.ext_interrupts = '0;
    in_if.speculative    = 1'b0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Configuration only lands at a reset, so these must leave the file alone.
    write_cfg(CFG_CPU_ID, 64'hff);
    write_cfg(CFG_PAL_BASE, '1);

    // Directed: reset values, masks, trap paths, denied accesses, odd actions.
    plan.push_back(mk(ACT_READ,   R_MCSR,        '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_CPU_SCRATCH, '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_SIRR,        '1,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_SIRR,        '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_IPLR,        '1,  '0,  '0, 1'b0));
    // Highest external line beats the highest priority level.
    plan.push_back(mk(ACT_CHECK,  R_ISR,         '0,  '0,  '1, 1'b0));
    plan.push_back(mk(ACT_READ,   R_ISR,         '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_INTID,       '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_SIRR,        '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_IPLR,        '0,  '0,  '0, 1'b0));
    // Only the unused top line pending: nothing found, no trap.
    plan.push_back(mk(ACT_CHECK,  R_ISR,         '0,  '0,  35'h4_0000_0000, 1'b0));
    // Lowest software level while misspeculating still traps.
    plan.push_back(mk(ACT_WRITE,  R_SIRR,        64'h10, '0, '0, 1'b0));
    plan.push_back(mk(ACT_CHECK,  R_ISR,         '0,  '0,  '0, 1'b1));
    // A pending trap request blocks the check.
    plan.push_back(mk(ACT_WRITE,  R_ASTRR,       '1,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_CHECK,  R_ISR,         '0,  '0,  '1, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_ASTRR,       '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_DC_TEST_TAG_TEMP, '0, '0, '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_INTID,       '1,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_ALT_MODE,    '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_ALT_MODE,    '1,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_SCRATCH0,    '1,  '0,  '0, 1'b1));
    plan.push_back(mk(ACT_WRITE,  R_MM_STAT,     '1,  '0,  '0, 1'b1));
    plan.push_back(mk(ACT_UNUSED, R_SCRATCH23,   '1,  '1,  '1, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_CC,          '1,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_CC,          '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_CC_CTL,      '0,  '0,  '0, 1'b0));
    plan.push_back(mk(ACT_WRITE,  R_EXC_ADDR,    '1,  '1,  '0, 1'b0));
    plan.push_back(mk(ACT_READ,   R_EXC_ADDR,    '0,  '1,  '0, 1'b0));
    foreach (plan[i]) push_item(plan[i]);
    in_if.valid = 1'b0;

    // Phase one: sender idles lightly, receiver stalls often.
    run_random(PHASE_ITEMS);
    drain();
    write_cfg(CFG_CPU_ID, '0);
    write_cfg(CFG_PAL_BASE, '0);
    write_cfg(CFG_SPARE, '1);

    // Phase two: swap the pressure.
    src_idle_pct  = 57;
    sink_idle_pct = 30;
    run_random(PHASE_ITEMS);
    drain();
    write_cfg(CFG_CPU_ID, 64'($urandom_range(255)));
    write_cfg(CFG_PAL_BASE, {$urandom, $urandom});

    // Phase three: full rate both ways, then confirm reset values held.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(PHASE_ITEMS);
    push_item(mk(ACT_READ, R_PAL_BASE, '0, '0, '0, 1'b0));
    push_item(mk(ACT_READ, R_CPU_SCRATCH, '0, '0, '0, 1'b0));
    in_if.valid = 1'b0;
    drain();
    repeat (10) @(negedge clk_i);

    $display("Covered %0d reads, %0d writes, %0d interrupt checks (%0d traps), %0d faults",
             sb.reads, sb.writes, sb.checks, sb.traps, sb.faults);
    $display("Compared %0d results, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
